[design/vnm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vnm_pkg: shared types and constants of the vector norm unit
// Widths of the accumulator and root search, mode codes, multiply unit bundles.
// ----------------------------------------------------------------------------
package vnm_pkg;

  localparam int ELEMENT_BITS_DEF = 12;
  localparam int LP_EXPONENT_DEF  = 5;

  localparam int ACC_W   = 64;
  localparam int HALF_W  = ACC_W / 2;
  localparam int ROOT_W  = 32;
  localparam int BIT_W   = $clog2(ROOT_W);
  localparam int NORM_W  = 24;
  localparam int MODE_W  = 2;

  localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_L1    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_L2    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_L2;
  localparam int                MODE_LP_BIT = 1;

  typedef struct packed {
    logic              start;
    logic [ACC_W-1:0]  a;
    logic [ROOT_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] p;
    logic             ovf;
  } mul_rsp_t;

endpackage
`default_nettype wire

[design/vector_norm_l1_l2_lp_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vector_norm_l1_l2_lp_top: vector L1 / L2 / Lp norm
// Accumulates per-element powers and takes the floored root on the last word.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_axis: one signed element per word, tlast on the
//   final element of a vector. One norm word leaves on m_axis per vector, with
//   the overflow flag in tuser. cfg_we/cfg_wdata write norm_mode (0 = L1,
//   1 = L2, 2 or 3 = Lp); write it only while the block is idle.
//   The block takes one word at a time. With k = 1, 2 or LP_EXPONENT for
//   L1, L2 or Lp, a word takes k multiplies on the shared unit and an add.
//   The last word adds a 32-step root search, each step setting a candidate
//   bit and taking k multiplies (none in L1), then loads the output.
//   The output register lets the next vector start while a norm is waiting;
//   a stalled receiver only holds the block when the next norm is ready.
//   Reset clears the accumulator and flag, empties the output register and
//   sets norm_mode to L2. No clearing pass is needed.
// ----------------------------------------------------------------------------
module vector_norm_l1_l2_lp_top #(
  parameter int ELEMENT_BITS = vnm_pkg::ELEMENT_BITS_DEF,
  parameter int LP_EXPONENT  = vnm_pkg::LP_EXPONENT_DEF,
  localparam int IN_TDATA_W  = ((ELEMENT_BITS + 7) / 8) * 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]       s_axis_tdata,   // element
  input  wire logic                        s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [vnm_pkg::NORM_W-1:0]       m_axis_tdata,   // norm
  output logic                             m_axis_tuser,   // overflow
  input  wire logic                        cfg_we,
  input  wire logic [vnm_pkg::MODE_W-1:0]  cfg_wdata       // norm_mode
);

  localparam int MAG_W = ELEMENT_BITS + 1;
  localparam int CNT_W = $clog2(LP_EXPONENT + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_TERM, S_ADD, S_RCAND, S_RMUL, S_RCMP, S_EMIT
  } state_t;

  state_t                        state;
  logic [vnm_pkg::MODE_W-1:0]    mode;
  logic [vnm_pkg::ACC_W-1:0]     power_sum;
  logic                          sat_seen;
  logic [vnm_pkg::ACC_W-1:0]     acc;
  logic                          acc_ovf;
  logic [vnm_pkg::ROOT_W-1:0]    opb;
  logic [vnm_pkg::ROOT_W-1:0]    res;
  logic [vnm_pkg::BIT_W-1:0]     bit_idx;
  logic [CNT_W-1:0]              cnt;
  logic                          last_q;
  logic                          mul_start;

  vnm_pkg::mul_req_t             mul_req;
  vnm_pkg::mul_rsp_t             mul_rsp;

  logic [ELEMENT_BITS-1:0]       raw;
  logic [MAG_W-1:0]              mag;
  logic                          is_lp;
  logic [CNT_W-1:0]              k;
  logic [vnm_pkg::ACC_W-1:0]     term;
  logic [vnm_pkg::ACC_W:0]       sum_w;
  logic [vnm_pkg::ACC_W-1:0]     sum_sat;
  logic [vnm_pkg::ROOT_W-1:0]    cand;
  logic [vnm_pkg::ACC_W-1:0]     norm_src;
  logic                          norm_big;

  assign raw   = s_axis_tdata[ELEMENT_BITS-1:0];
  assign mag   = raw[ELEMENT_BITS-1] ? ({1'b1, {ELEMENT_BITS{1'b0}}} - {1'b0, raw})
                                     : {1'b0, raw};
  assign is_lp = mode[vnm_pkg::MODE_LP_BIT];

  always_comb begin
    if (is_lp)                        k = CNT_W'(LP_EXPONENT);
    else if (mode == vnm_pkg::MODE_L2) k = CNT_W'(2);
    else                              k = CNT_W'(1);
  end

  assign term     = acc_ovf ? {vnm_pkg::ACC_W{1'b1}} : acc;
  assign sum_w    = {1'b0, power_sum} + {1'b0, term};
  assign sum_sat  = sum_w[vnm_pkg::ACC_W] ? {vnm_pkg::ACC_W{1'b1}}
                                          : sum_w[vnm_pkg::ACC_W-1:0];
  assign cand     = res | (vnm_pkg::ROOT_W'(1) << bit_idx);
  assign norm_src = (mode == vnm_pkg::MODE_L1) ? power_sum
                                               : {{(vnm_pkg::ACC_W-vnm_pkg::ROOT_W){1'b0}}, res};
  assign norm_big = |norm_src[vnm_pkg::ACC_W-1:vnm_pkg::NORM_W];

  assign s_axis_tready = (state == S_IDLE);

  assign mul_req.start = mul_start;
  assign mul_req.a     = acc;
  assign mul_req.b     = opb;

  vnm_satmul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  always_ff @(posedge clk) begin
    mul_start <= 1'b0;
    if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
    if (cfg_we) mode <= cfg_wdata;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          opb       <= vnm_pkg::ROOT_W'(mag);
          last_q    <= s_axis_tlast;
          acc       <= vnm_pkg::ACC_W'(1);
          acc_ovf   <= 1'b0;
          cnt       <= k;
          mul_start <= 1'b1;
          state     <= S_TERM;
        end
      end
      S_TERM, S_RMUL: begin
        if (mul_rsp.done) begin
          acc     <= mul_rsp.p;
          acc_ovf <= acc_ovf | mul_rsp.ovf;
          cnt     <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= (state == S_TERM) ? S_ADD : S_RCMP;
          end else begin
            mul_start <= 1'b1;
          end
        end
      end
      S_ADD: begin
        power_sum <= sum_sat;
        sat_seen  <= sat_seen | sum_w[vnm_pkg::ACC_W];
        if (!last_q) begin
          state <= S_IDLE;
        end else if (mode == vnm_pkg::MODE_L1) begin
          state <= S_EMIT;
        end else begin
          res     <= '0;
          bit_idx <= vnm_pkg::BIT_W'(vnm_pkg::ROOT_W - 1);
          state   <= S_RCAND;
        end
      end
      S_RCAND: begin
        opb       <= cand;
        acc       <= vnm_pkg::ACC_W'(1);
        acc_ovf   <= 1'b0;
        cnt       <= k;
        mul_start <= 1'b1;
        state     <= S_RMUL;
      end
      S_RCMP: begin
        if (!acc_ovf && acc <= power_sum) res <= opb;
        if (bit_idx == '0) begin
          state <= S_EMIT;
        end else begin
          bit_idx <= bit_idx - vnm_pkg::BIT_W'(1);
          state   <= S_RCAND;
        end
      end
      S_EMIT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= norm_big ? vnm_pkg::NORM_MAX : norm_src[vnm_pkg::NORM_W-1:0];
          m_axis_tuser  <= sat_seen | norm_big;
          power_sum     <= '0;
          sat_seen      <= 1'b0;
          state         <= S_IDLE;
        end
      end
      default: state <= S_IDLE;
    endcase
    if (rst) begin
      state         <= S_IDLE;
      mode          <= vnm_pkg::MODE_RESET;
      power_sum     <= '0;
      sat_seen      <= 1'b0;
      mul_start     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end
  end

  a_ready_no_mul: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !mul_start)
    else $error("input ready while a multiply is requested");

  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_TERM || state == S_RMUL) |-> cnt != '0)
    else $error("multiply loop running with zero count");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == S_TERM || state == S_RMUL))
    else $error("multiply result outside a multiply loop");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && (!m_axis_tvalid || m_axis_tready))
      |=> (m_axis_tvalid && power_sum == '0 && !sat_seen))
    else $error("emit did not load output and clear accumulator");

endmodule
`default_nettype wire

[design/vnm_satmul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vnm_satmul: shared saturating multiplier
// 64 x 32 product through one 32 x 32 multiplier in two halves, then merge.
// ----------------------------------------------------------------------------
module vnm_satmul (
  input  wire logic          clk,
  input  wire logic          rst,
  input  vnm_pkg::mul_req_t  req,
  output vnm_pkg::mul_rsp_t  rsp
);

  typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_SUM} mstate_t;

  mstate_t                        state;
  logic [2*vnm_pkg::HALF_W-1:0]   p_lo;
  logic [2*vnm_pkg::HALF_W-1:0]   p_hi;
  logic [vnm_pkg::HALF_W-1:0]     mul_x;
  logic [2*vnm_pkg::HALF_W-1:0]   product;
  logic [vnm_pkg::HALF_W:0]       mid;

  assign mul_x   = (state == M_HI) ? req.a[vnm_pkg::ACC_W-1:vnm_pkg::HALF_W]
                                   : req.a[vnm_pkg::HALF_W-1:0];
  assign product = mul_x * req.b;
  assign mid     = {1'b0, p_lo[2*vnm_pkg::HALF_W-1:vnm_pkg::HALF_W]}
                 + {1'b0, p_hi[vnm_pkg::HALF_W-1:0]};

  always_ff @(posedge clk) begin
    rsp.done <= 1'b0;
    unique case (state)
      M_IDLE: begin
        if (req.start) state <= M_LO;
      end
      M_LO: begin
        p_lo  <= product;
        state <= M_HI;
      end
      M_HI: begin
        p_hi  <= product;
        state <= M_SUM;
      end
      M_SUM: begin
        rsp.ovf  <= (|p_hi[2*vnm_pkg::HALF_W-1:vnm_pkg::HALF_W]) | mid[vnm_pkg::HALF_W];
        rsp.p    <= ((|p_hi[2*vnm_pkg::HALF_W-1:vnm_pkg::HALF_W]) | mid[vnm_pkg::HALF_W])
                    ? {vnm_pkg::ACC_W{1'b1}}
                    : {mid[vnm_pkg::HALF_W-1:0], p_lo[vnm_pkg::HALF_W-1:0]};
        rsp.done <= 1'b1;
        state    <= M_IDLE;
      end
      default: state <= M_IDLE;
    endcase
    if (rst) begin
      state    <= M_IDLE;
      rsp.done <= 1'b0;
    end
  end

endmodule
`default_nettype wire
